// ----- sv/pti_pkg.sv -----
// Package for the perspective texcoord interpolator: field widths, payload and
// configuration types, register indexes and queue depth defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pti_pkg;

	localparam int SCREEN_W   = 16;              // Q12.4 screen coordinate
	localparam int ATTR_WIDTH = 16;              // Q0.16 texture coordinate
	localparam int Z_W        = 16;              // Q4.12 inverse depth
	localparam int DEPTH_FRAC = 12;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_ADDR_W = 3;

	localparam int Q_W   = SCREEN_W + 1;         // pixel minus vertex
	localparam int K_W   = 2 * Q_W + 1;          // edge weight
	localparam int L_W   = K_W + 2;              // weight sum
	localparam int PRE_W = ATTR_WIDTH + Z_W - DEPTH_FRAC;   // u*z premultiplied
	localparam int PZ_W  = K_W + Z_W + 1;
	localparam int PA_W  = K_W + PRE_W + 1;
	localparam int SUM_W = PA_W + 2;
	localparam int PQ_W  = ATTR_WIDTH + 17;      // clamp range 0..2^(ATTR_WIDTH+16)
	localparam int NUM2_W = PQ_W + DEPTH_FRAC;

	localparam int PTI_Q_DEPTH   = 4;
	localparam int PTI_OUT_DEPTH = 4;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_PERSPECTIVE_MODE = 3'd0,
		CFG_VERT_A_SCREEN    = 3'd1,
		CFG_VERT_B_SCREEN    = 3'd2,
		CFG_VERT_C_SCREEN    = 3'd3,
		CFG_VERT_A_TEX       = 3'd4,
		CFG_VERT_B_TEX       = 3'd5,
		CFG_VERT_C_TEX       = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic              perspective_mode;
		logic [2:0][47:0]  screen;
		logic [2:0][31:0]  tex;
	} cfg_t;

	typedef struct packed {
		logic signed [SCREEN_W-1:0] pixel_x;
		logic signed [SCREEN_W-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic [15:0] inv_depth;
		logic        degenerate;
	} result_t;

	// edge weights of one pixel, passed from front to back
	typedef struct packed {
		logic [K_W-1:0] k0;
		logic [K_W-1:0] k1;
		logic [K_W-1:0] k2;
		logic [L_W-1:0] l;
	} work_t;

endpackage
`default_nettype wire

// ----- sv/perspective_texcoord_interpolator_unit.sv -----
// Top level of the perspective texcoord interpolator: configuration registers,
// front end, work queue, back end and result queue. Depends on pti_pkg and all pti_* modules.
`timescale 1ns / 1ps
`default_nettype none
// Takes one pixel item per clock while full is low and returns one result item per pixel, in
// order. Sustained rate is one item per cycle while results are popped. Between input and
// output lie two weight stages in the front, the work queue, five datapath stages and the
// two pipelined restoring divider chains in the back end (58 stages for the normalization by the
// weight sum, 45 for the perspective divide).
// The triangle setup lives in seven registers written through cfg_wr_en /
// cfg_addr / cfg_wdata; write them only while no item is in flight. Results
// wait in a small output queue, so pop may idle without stopping the input
// until that queue and the work queue both fill up.
module perspective_texcoord_interpolator_unit
	import pti_pkg::*;
#(
	parameter int Q_DEPTH   = PTI_Q_DEPTH,
	parameter int OUT_DEPTH = PTI_OUT_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// pixel side
	input  wire logic                  push,
	input  wire pixel_t                pixel,
	output logic                       full,
	// result side
	output logic                       empty,
	input  wire logic                  pop,
	output result_t                    result,
	// configuration writes
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int QCNT_W = $clog2(Q_DEPTH + 1);

	cfg_t cfg_q;

	// register file; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.perspective_mode <= 1'b1;
			cfg_q.screen           <= '0;
			cfg_q.tex              <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_addr))
				CFG_PERSPECTIVE_MODE: cfg_q.perspective_mode <= cfg_wdata[0];
				CFG_VERT_A_SCREEN:    cfg_q.screen[0] <= cfg_wdata;
				CFG_VERT_B_SCREEN:    cfg_q.screen[1] <= cfg_wdata;
				CFG_VERT_C_SCREEN:    cfg_q.screen[2] <= cfg_wdata;
				CFG_VERT_A_TEX:       cfg_q.tex[0] <= cfg_wdata[31:0];
				CFG_VERT_B_TEX:       cfg_q.tex[1] <= cfg_wdata[31:0];
				CFG_VERT_C_TEX:       cfg_q.tex[2] <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	logic              wq_push, wq_pop, wq_empty, wq_full;
	work_t             wq_wdata, wq_rdata;
	logic [QCNT_W-1:0] wq_count;
	logic              rq_push, rq_full;
	result_t           rq_wdata;

	// front: weights per pixel; its full accounts for items still in flight
	pti_front #(.Q_DEPTH(Q_DEPTH)) u_front (
		.clk, .arst_n, .push, .pixel, .full, .cfg(cfg_q),
		.q_count(wq_count), .q_push(wq_push), .q_data(wq_wdata)
	);

	// decouples the front from back end stalls
	pti_fifo #(.WIDTH($bits(work_t)), .DEPTH(Q_DEPTH)) u_work_q (
		.clk, .arst_n, .push(wq_push), .wdata(wq_wdata), .pop(wq_pop),
		.rdata(wq_rdata), .full(wq_full), .empty(wq_empty), .count(wq_count)
	);

	pti_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_empty(wq_empty), .q_data(wq_rdata),
		.q_pop(wq_pop), .out_full(rq_full), .out_push(rq_push), .out_data(rq_wdata)
	);

	// result queue: the oldest result sits on the result port while not empty
	pti_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_result_q (
		.clk, .arst_n, .push(rq_push), .wdata(rq_wdata), .pop,
		.rdata(result), .full(rq_full), .empty, .count()
	);

	a_work_q_room: assert property (@(posedge clk) disable iff (!arst_n)
		wq_push |-> !wq_full)
		else $error("work queue overrun");

endmodule
`default_nettype wire

// ----- sv/pti_fifo.sv -----
// Small synchronous queue with push/full and pop/empty sides and a fill count.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pti_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty,
	output logic      [CNT_W-1:0] count
);

	logic [WIDTH-1:0]  slots_q [DEPTH];
	logic [ADDR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ----- sv/pti_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband carried alongside and a sticky flag for quotient bits above QUO_W.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pti_div #(
	parameter int NUM_W  = 16,
	parameter int DEN_W  = 8,
	parameter int QUO_W  = 8,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side,
	output logic                   out_valid,
	output logic      [QUO_W-1:0]  quo,
	output logic                   ovf,
	output logic      [SIDE_W-1:0] side_out
);

	// index 0 is the input register, index NUM_W the finished quotient
	logic [NUM_W:0]      vld_s;
	logic [NUM_W-1:0]    num_s  [NUM_W+1];
	logic [DEN_W-1:0]    den_s  [NUM_W+1];
	logic [DEN_W-1:0]    rem_s  [NUM_W+1];
	logic [QUO_W-1:0]    quo_s  [NUM_W+1];
	logic                ovf_s  [NUM_W+1];
	logic [SIDE_W-1:0]   side_s [NUM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NUM_W-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0]  <= num;
			den_s[0]  <= den;
			rem_s[0]  <= '0;
			quo_s[0]  <= '0;
			ovf_s[0]  <= 1'b0;
			side_s[0] <= side;
		end
	end

	for (genvar j = 0; j < NUM_W; j++) begin : g_step
		logic [DEN_W:0] trial, diff;
		logic           ge;

		assign trial = {rem_s[j], num_s[j][NUM_W-1]};
		assign diff  = trial - {1'b0, den_s[j]};
		assign ge    = (trial >= {1'b0, den_s[j]});

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[j+1]  <= num_s[j] << 1;
				den_s[j+1]  <= den_s[j];
				rem_s[j+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_s[j+1]  <= {quo_s[j][QUO_W-2:0], ge};
				ovf_s[j+1]  <= ovf_s[j] | quo_s[j][QUO_W-1];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign quo       = quo_s[NUM_W];
	assign ovf       = ovf_s[NUM_W];
	assign side_out  = side_s[NUM_W];

endmodule
`default_nettype wire

// ----- sv/pti_front.sv -----
// Front end: accepts pixel items, forms an edge weight per vertex and their sum,
// and pushes them into the work queue. Depends on pti_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pti_front
	import pti_pkg::*;
#(
	parameter int Q_DEPTH = PTI_Q_DEPTH,
	localparam int CNT_W = $clog2(Q_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire pixel_t           pixel,
	output logic                  full,
	input  wire cfg_t             cfg,
	input  wire logic [CNT_W-1:0] q_count,
	output logic                  q_push,
	output work_t                 q_data
);

	logic                  valid_s1, valid_s2;
	logic signed [Q_W-1:0] qx_s1 [3];
	logic signed [Q_W-1:0] qy_s1 [3];
	logic signed [K_W-1:0] k_s2 [3];
	logic signed [L_W-1:0] l_sum;
	logic                  accept;

	// room is reserved for everything already in flight ahead of the queue
	assign full = ({1'b0, q_count} + (CNT_W+1)'(valid_s1) + (CNT_W+1)'(valid_s2))
		>= (CNT_W+1)'(Q_DEPTH);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			qx_s1[i] <= $signed({pixel.pixel_x[SCREEN_W-1], pixel.pixel_x})
				- $signed({cfg.screen[i][15], cfg.screen[i][15:0]});
			qy_s1[i] <= $signed({pixel.pixel_y[SCREEN_W-1], pixel.pixel_y})
				- $signed({cfg.screen[i][31], cfg.screen[i][31:16]});
		end
		k_s2[0] <= qx_s1[1] * qy_s1[2] - qy_s1[1] * qx_s1[2];
		k_s2[1] <= qx_s1[2] * qy_s1[0] - qy_s1[2] * qx_s1[0];
		k_s2[2] <= qx_s1[0] * qy_s1[1] - qy_s1[0] * qx_s1[1];
	end

	assign l_sum     = L_W'(k_s2[0]) + L_W'(k_s2[1]) + L_W'(k_s2[2]);
	assign q_push    = valid_s2;
	assign q_data.k0 = k_s2[0];
	assign q_data.k1 = k_s2[1];
	assign q_data.k2 = k_s2[2];
	assign q_data.l  = l_sum;

endmodule
`default_nettype wire

// ----- sv/pti_back.sv -----
// Back end: weighted sums, normalization by the weight sum, perspective divide,
// saturation and the degenerate flag. Depends on pti_pkg and pti_div.
`timescale 1ns / 1ps
`default_nettype none
module pti_back
	import pti_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  q_empty,
	input  wire work_t q_data,
	output logic       q_pop,
	input  wire logic  out_full,
	output logic       out_push,
	output result_t    out_data
);

	localparam int SIDE1_W = 4;
	localparam int SIDE2_W = 1 + Z_W + 2 * ATTR_WIDTH;

	function automatic logic [PRE_W-1:0] premul(input logic [ATTR_WIDTH-1:0] a,
		input logic [Z_W-1:0] z);
		logic [ATTR_WIDTH+Z_W:0] t;
		t = (ATTR_WIDTH+Z_W+1)'(a) * (ATTR_WIDTH+Z_W+1)'(z)
			+ (ATTR_WIDTH+Z_W+1)'(1 << (DEPTH_FRAC - 1));
		return t[DEPTH_FRAC+PRE_W-1:DEPTH_FRAC];
	endfunction

	function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] x);
		return x[SUM_W-1] ? SUM_W'(-x) : x;
	endfunction

	function automatic logic [ATTR_WIDTH-1:0] sat_attr(input logic [PQ_W-1:0] q,
		input logic o, input logic neg);
		if (neg) return '0;
		if (o || (q[PQ_W-1:ATTR_WIDTH] != '0)) return '1;
		return q[ATTR_WIDTH-1:0];
	endfunction

	function automatic logic [PQ_W-1:0] sat_pre(input logic [PQ_W-1:0] q,
		input logic o, input logic neg);
		if (neg) return '0;
		if (o || q[PQ_W-1]) return {1'b1, {(PQ_W-1){1'b0}}};
		return q;
	endfunction

	logic en;

	// premultiplied attributes depend on configuration only
	logic [PRE_W-1:0] pu_q [3];
	logic [PRE_W-1:0] pv_q [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pu_q[i] <= premul(cfg.tex[i][ATTR_WIDTH-1:0], cfg.screen[i][47:32]);
			pv_q[i] <= premul(cfg.tex[i][2*ATTR_WIDTH-1:ATTR_WIDTH], cfg.screen[i][47:32]);
		end
	end

	// stage 1: weights from the queue
	logic                  valid_s1;
	logic signed [K_W-1:0] k_s1 [3];
	logic signed [L_W-1:0] l_s1;

	// stage 2: products
	logic                   valid_s2;
	logic signed [PZ_W-1:0] pz_s2 [3];
	logic signed [PA_W-1:0] pu_s2 [3];
	logic signed [PA_W-1:0] pv_s2 [3];
	logic signed [L_W-1:0]  l_s2;

	// stage 3: sums
	logic                    valid_s3;
	logic signed [SUM_W-1:0] sz_s3, su_s3, sv_s3;
	logic signed [L_W-1:0]   l_s3;

	// stage 4: magnitudes and quotient signs
	logic             valid_s4, lzero_s4, negz_s4, negu_s4, negv_s4;
	logic [SUM_W-1:0] magz_s4, magu_s4, magv_s4;
	logic [L_W-1:0]   magl_s4;

	assign q_pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= q_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1[0] <= $signed(q_data.k0);
			k_s1[1] <= $signed(q_data.k1);
			k_s1[2] <= $signed(q_data.k2);
			l_s1    <= $signed(q_data.l);

			for (int i = 0; i < 3; i++) begin
				pz_s2[i] <= k_s1[i] * $signed({1'b0, cfg.screen[i][47:32]});
				pu_s2[i] <= k_s1[i] * $signed({1'b0, cfg.perspective_mode ? pu_q[i]
					: PRE_W'(cfg.tex[i][ATTR_WIDTH-1:0])});
				pv_s2[i] <= k_s1[i] * $signed({1'b0, cfg.perspective_mode ? pv_q[i]
					: PRE_W'(cfg.tex[i][2*ATTR_WIDTH-1:ATTR_WIDTH])});
			end
			l_s2 <= l_s1;

			sz_s3 <= SUM_W'(pz_s2[0]) + SUM_W'(pz_s2[1]) + SUM_W'(pz_s2[2]);
			su_s3 <= SUM_W'(pu_s2[0]) + SUM_W'(pu_s2[1]) + SUM_W'(pu_s2[2]);
			sv_s3 <= SUM_W'(pv_s2[0]) + SUM_W'(pv_s2[1]) + SUM_W'(pv_s2[2]);
			l_s3  <= l_s2;

			lzero_s4 <= (l_s3 == '0);
			negz_s4  <= sz_s3[SUM_W-1] ^ l_s3[L_W-1];
			negu_s4  <= su_s3[SUM_W-1] ^ l_s3[L_W-1];
			negv_s4  <= sv_s3[SUM_W-1] ^ l_s3[L_W-1];
			magz_s4  <= mag(sz_s3);
			magu_s4  <= mag(su_s3);
			magv_s4  <= mag(sv_s3);
			magl_s4  <= l_s3[L_W-1] ? L_W'(-l_s3) : l_s3;
		end
	end

	// normalization by the weight sum, rounding half away from zero
	logic [L_W-1:0]     den1;
	logic               d1_valid, ovfz, ovfu, ovfv;
	logic [PQ_W-1:0]    qz, qu, qv;
	logic [SIDE1_W-1:0] side1;
	logic               unused_vu, unused_vv;
	logic [SIDE1_W-1:0] unused_su, unused_sv;

	assign den1 = lzero_s4 ? L_W'(1) : magl_s4;

	pti_div #(.NUM_W(SUM_W), .DEN_W(L_W), .QUO_W(PQ_W), .SIDE_W(SIDE1_W)) u_div_z (
		.clk, .arst_n, .en, .in_valid(valid_s4),
		.num(magz_s4 + SUM_W'(magl_s4 >> 1)), .den(den1),
		.side({lzero_s4, negz_s4, negu_s4, negv_s4}),
		.out_valid(d1_valid), .quo(qz), .ovf(ovfz), .side_out(side1)
	);
	pti_div #(.NUM_W(SUM_W), .DEN_W(L_W), .QUO_W(PQ_W), .SIDE_W(SIDE1_W)) u_div_u (
		.clk, .arst_n, .en, .in_valid(valid_s4),
		.num(magu_s4 + SUM_W'(magl_s4 >> 1)), .den(den1),
		.side(SIDE1_W'(0)),
		.out_valid(unused_vu), .quo(qu), .ovf(ovfu), .side_out(unused_su)
	);
	pti_div #(.NUM_W(SUM_W), .DEN_W(L_W), .QUO_W(PQ_W), .SIDE_W(SIDE1_W)) u_div_v (
		.clk, .arst_n, .en, .in_valid(valid_s4),
		.num(magv_s4 + SUM_W'(magl_s4 >> 1)), .den(den1),
		.side(SIDE1_W'(0)),
		.out_valid(unused_vv), .quo(qv), .ovf(ovfv), .side_out(unused_sv)
	);

	// stage 5: clamped depth and attributes
	logic                  valid_s5, lzero_s5;
	logic [Z_W-1:0]        zi_s5;
	logic [PQ_W-1:0]       pu_s5, pv_s5;
	logic [ATTR_WIDTH-1:0] ou_s5, ov_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lzero_s5 <= side1[3];
			zi_s5    <= sat_attr(qz, ovfz, side1[2]);
			pu_s5    <= sat_pre(qu, ovfu, side1[1]);
			pv_s5    <= sat_pre(qv, ovfv, side1[0]);
			ou_s5    <= sat_attr(qu, ovfu, side1[1]);
			ov_s5    <= sat_attr(qv, ovfv, side1[0]);
		end
	end

	// perspective divide by the interpolated inverse depth
	logic [Z_W-1:0]        den2;
	logic                  d2_valid, ovf2u, ovf2v;
	logic [ATTR_WIDTH-1:0] q2u, q2v;
	logic [SIDE2_W-1:0]    side2, unused_s2;
	logic                  unused_v2;

	assign den2 = (zi_s5 == '0) ? Z_W'(1) : zi_s5;

	pti_div #(.NUM_W(NUM2_W), .DEN_W(Z_W), .QUO_W(ATTR_WIDTH), .SIDE_W(SIDE2_W)) u_div_pu (
		.clk, .arst_n, .en, .in_valid(valid_s5),
		.num({pu_s5, {DEPTH_FRAC{1'b0}}} + NUM2_W'(zi_s5 >> 1)), .den(den2),
		.side({lzero_s5, zi_s5, ou_s5, ov_s5}),
		.out_valid(d2_valid), .quo(q2u), .ovf(ovf2u), .side_out(side2)
	);
	pti_div #(.NUM_W(NUM2_W), .DEN_W(Z_W), .QUO_W(ATTR_WIDTH), .SIDE_W(SIDE2_W)) u_div_pv (
		.clk, .arst_n, .en, .in_valid(valid_s5),
		.num({pv_s5, {DEPTH_FRAC{1'b0}}} + NUM2_W'(zi_s5 >> 1)), .den(den2),
		.side(SIDE2_W'(0)),
		.out_valid(unused_v2), .quo(q2v), .ovf(ovf2v), .side_out(unused_s2)
	);

	logic                  f_lzero, f_zzero;
	logic [Z_W-1:0]        f_zi;
	logic [ATTR_WIDTH-1:0] f_ou, f_ov;

	assign {f_lzero, f_zi, f_ou, f_ov} = side2;
	assign f_zzero = (f_zi == '0);

	always_comb begin
		out_data.degenerate = f_lzero || f_zzero;
		out_data.inv_depth  = f_lzero ? '0 : f_zi;
		if (f_lzero) begin
			out_data.tex_u = '0;
			out_data.tex_v = '0;
		end else if (cfg.perspective_mode) begin
			out_data.tex_u = f_zzero ? '0 : (ovf2u ? '1 : q2u);
			out_data.tex_v = f_zzero ? '0 : (ovf2v ? '1 : q2v);
		end else begin
			out_data.tex_u = f_ou;
			out_data.tex_v = f_ov;
		end
	end

	// the whole back end holds only while a finished item has nowhere to go
	assign en       = !(d2_valid && out_full);
	assign out_push = d2_valid && !out_full;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into a full output queue");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("work queue popped while empty");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(d2_valid && out_full) |=> d2_valid)
		else $error("finished item lost during stall");
	a_degen_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (out_data.degenerate == (out_data.inv_depth == '0)))
		else $error("degenerate flag disagrees with inverse depth");

endmodule
`default_nettype wire
